// File: design/pip_pkg.sv
package pip_pkg;

	// Fixed port widths
	localparam int COORD_PORT_W = 32;
	localparam int INDEX_W      = 6;
	localparam int COUNT_W      = 7;

	// Parameter defaults
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;

	// Request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TEST  = 1'b1;

	// Last flush step, when the edge pipeline has settled
	localparam logic [1:0] FLUSH_LAST = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} pip_state_t;

	// Control from the sequencer to the edge unit
	typedef struct packed {
		logic clear;
		logic valid;
	} pip_edge_ctl_t;

endpackage

// File: design/pip_vtx_cell.sv
module pip_vtx_cell #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic                          wr_en,
	input  logic signed [COORD_WIDTH-1:0] wr_x,
	input  logic signed [COORD_WIDTH-1:0] wr_y,
	input  logic signed [COORD_WIDTH-1:0] nb_x,
	input  logic signed [COORD_WIDTH-1:0] nb_y,
	output logic signed [COORD_WIDTH-1:0] x,
	output logic signed [COORD_WIDTH-1:0] y
);

	logic signed [COORD_WIDTH-1:0] x_q;
	logic signed [COORD_WIDTH-1:0] y_q;

	// Load a written vertex, else take the neighbour's vertex while the ring turns
	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end else if (shift) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

// File: design/pip_edge_unit.sv
module pip_edge_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_pkg::pip_edge_ctl_t        ctl,
	input  logic signed [COORD_WIDTH-1:0] xi,
	input  logic signed [COORD_WIDTH-1:0] yi,
	input  logic signed [COORD_WIDTH-1:0] xj,
	input  logic signed [COORD_WIDTH-1:0] yj,
	input  logic signed [COORD_WIDTH-1:0] qx,
	input  logic signed [COORD_WIDTH-1:0] qy,
	output logic                          in_poly
);
	import pip_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic                 valid_s1, valid_s2;
	logic                 straddle_s1, straddle_s2;
	logic                 flag1_s1, flag1_s2;
	logic signed [DW-1:0] dyq_s1, dx_s1, dxq_s1, dy_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [PW-1:0] p1, p2;
	logic                 flag0, flag1;
	logic                 toggle;
	logic                 inside_q;

	assign flag0 = (yj >= qy);
	assign flag1 = (yi >= qy);

	// Stage 1: exact differences and the straddle test
	always_ff @(posedge clk) begin
		dyq_s1      <= DW'(yi) - DW'(qy);
		dx_s1       <= DW'(xj) - DW'(xi);
		dxq_s1      <= DW'(xi) - DW'(qx);
		dy_s1       <= DW'(yj) - DW'(yi);
		straddle_s1 <= (flag0 != flag1);
		flag1_s1    <= flag1;
	end

	// Stage 2: the two cross products, full width
	assign p1 = dyq_s1 * dx_s1;
	assign p2 = dxq_s1 * dy_s1;

	always_ff @(posedge clk) begin
		p1_s2       <= p1;
		p2_s2       <= p2;
		straddle_s2 <= straddle_s1;
		flag1_s2    <= flag1_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Toggle on a valid straddling edge when the product comparison matches the upper flag
	assign toggle = valid_s2 && straddle_s2 && ((p1_s2 >= p2_s2) == flag1_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (ctl.clear) begin
			inside_q <= 1'b0;
		end else if (toggle) begin
			inside_q <= !inside_q;
		end
	end

	assign in_poly = inside_q;

endmodule

// File: design/point_in_polygon_test_core.sv
// Vertex write: no result.
// Test: the vertex ring turns once past the single edge unit (one edge per cycle), then its
// 3-stage pipe drains and the result is loaded into the result register.
// Tests do not overlap: in_stall stays high while a test runs, until its result is loaded.
// Reset clears the vertex count, the sequencer and the result valid flag; vertex cells are not reset.
module point_in_polygon_test_core #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic        [pip_pkg::COUNT_W-1:0]      cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    func,
	input  logic        [pip_pkg::INDEX_W-1:0]      vertex_index,
	input  logic signed [pip_pkg::COORD_PORT_W-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_PORT_W-1:0] coord_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    inside_res
);
	import pip_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int STEP_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_VERTICES - 1);

	logic [COUNT_W-1:0]   vertex_count_q;
	pip_state_t           state_q, state_d;
	logic [STEP_W-1:0]    step_q;
	logic [1:0]           fcnt_q;
	logic [CNT_W-1:0]     n_q;
	logic signed [CW-1:0] qx_q, qy_q;
	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                 out_valid_q, inside_res_q;

	logic                 in_acc, wr_req, test_req, shift, result_load, step_used;
	logic signed [CW-1:0] in_x, in_y;
	logic signed [CW-1:0] vi_x, vi_y;
	logic                 in_poly;
	pip_edge_ctl_t        edge_ctl;

	logic signed [CW-1:0] cell_x [MAX_VERTICES];
	logic signed [CW-1:0] cell_y [MAX_VERTICES];

	assign in_acc   = in_valid && !in_stall;
	assign wr_req   = in_acc && (func == FUNC_WRITE);
	assign test_req = in_acc && (func == FUNC_TEST);
	assign in_x     = $signed(coord_x[CW-1:0]);
	assign in_y     = $signed(coord_y[CW-1:0]);
	assign step_used = (CNT_W'(step_q) < n_q);

	// Hold the vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// Vertex ring: cell 0 is the head, each cell takes from the next one up
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		pip_vtx_cell #(
			.COORD_WIDTH(CW)
		) u_cell (
			.clk  (clk),
			.shift(shift),
			.wr_en(wr_req && (int'(vertex_index) == k)),
			.wr_x (in_x),
			.wr_y (in_y),
			.nb_x (cell_x[(k + 1) % MAX_VERTICES]),
			.nb_y (cell_y[(k + 1) % MAX_VERTICES]),
			.x    (cell_x[k]),
			.y    (cell_y[k])
		);
	end

	// Sequencer: next state and edge feed
	always_comb begin
		state_d        = state_q;
		in_stall       = (state_q != S_IDLE);
		shift          = 1'b0;
		result_load    = 1'b0;
		edge_ctl.clear = test_req;
		edge_ctl.valid = 1'b0;
		vi_x           = cell_x[0];
		vi_y           = cell_y[0];
		unique case (state_q)
			S_IDLE: begin
				if (test_req) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				shift          = 1'b1;
				edge_ctl.valid = (step_q != '0) && step_used;
				if (step_q == STEP_LAST) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// close the polygon with the edge from the last vertex to vertex 0
				vi_x           = first_x_q;
				vi_y           = first_y_q;
				edge_ctl.valid = (fcnt_q == '0) && (n_q != '0);
				if ((fcnt_q == FLUSH_LAST) && (!out_valid_q || !out_stall)) begin
					result_load = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			fcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			// advance the ring position; it wraps home after one full turn
			if (state_q == S_WALK) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
				fcnt_q <= '0;
			end else if ((state_q == S_FLUSH) && (fcnt_q != FLUSH_LAST)) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end

	// Capture the query point and the clipped vertex count
	always_ff @(posedge clk) begin
		if (test_req) begin
			qx_q <= in_x;
			qy_q <= in_y;
			n_q  <= (int'(vertex_count_q) > MAX_VERTICES) ?
			        CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_q);
		end
	end

	// Keep vertex 0 and the previous vertex while the ring turns
	always_ff @(posedge clk) begin
		if (state_q == S_WALK) begin
			if (step_q == '0) begin
				first_x_q <= cell_x[0];
				first_y_q <= cell_y[0];
			end
			if (step_used) begin
				prev_x_q <= cell_x[0];
				prev_y_q <= cell_y[0];
			end
		end
	end

	pip_edge_unit #(
		.COORD_WIDTH(CW)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (edge_ctl),
		.xi     (vi_x),
		.yi     (vi_y),
		.xj     (prev_x_q),
		.yj     (prev_y_q),
		.qx     (qx_q),
		.qy     (qy_q),
		.in_poly(in_poly)
	);

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			inside_res_q <= in_poly;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;

	// A test request starts a walk from the home position of the ring
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		test_req |=> (state_q == S_WALK) && (step_q == '0))
		else $error("test request did not start a walk");

	// The ring is back home whenever the block is idle
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (step_q == '0))
		else $error("vertex ring not at home position while idle");

	// A finished flush always delivers a result
	a_flush_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FLUSH) && (fcnt_q == FLUSH_LAST) && (!out_valid_q || !out_stall))
		|=> out_valid_q && (state_q == S_IDLE))
		else $error("flush finished without a result");

endmodule
